@@ hdl/skil_pkg.sv @@
// Shared types and constants for the string key linear probe index unit.
// No dependencies; every other file of the block but skil_if and skil_ram uses this package.
`default_nettype none
package skil_pkg;

  // TABLE_SLOTS is a power of two: the home slot is the low hash bits.
  localparam int unsigned TABLE_SLOTS = 128;
  localparam int unsigned KEY_BYTES   = 16;

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned LEN_W   = $clog2(KEY_BYTES + 1);
  localparam int unsigned TEXT_W  = KEY_BYTES * 8;
  localparam int unsigned ENTRY_W = 6;
  localparam int unsigned ROW_W   = ENTRY_W + LEN_W + TEXT_W;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_INSERT = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;
  localparam logic [1:0] FN_DROP   = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FOUND = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_LONG  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_PROBE,
    PS_CMP
  } probe_state_e;

  // Key state as seen on the word that ends a key.
  typedef struct packed {
    logic [SLOT_W-1:0] home;
    logic [LEN_W-1:0]  len;
    logic              overflow;
  } key_info_t;

endpackage
`default_nettype wire

@@ hdl/skil_if.sv @@
// Request and response channel interfaces for the probe index unit.
// No dependencies.
`default_nettype none
interface skil_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] key_byte;
  logic       key_last;
  logic [5:0] entry_index;
  modport source (output valid, func, key_byte, key_last, entry_index, input ready);
  modport sink (input valid, func, key_byte, key_last, entry_index, output ready);
endinterface

interface skil_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] found_index;
  modport source (output valid, status, found_index, input ready);
  modport sink (input valid, status, found_index, output ready);
endinterface
`default_nettype wire

@@ hdl/string_key_linear_probe_index_unit.sv @@
// Top level of the string key linear probe index unit.
// Depends on skil_pkg, skil_if, skil_ram, skil_key_buf, skil_probe.
//
// Usage:
//   req_i carries one key byte per word (func, key_byte, key_last,
//   entry_index). Bytes hash into a djb2 sum at one word per cycle while
//   req_i.ready is high. The word with key_last set runs func: clear,
//   insert or lookup; a func of three drops the key with no response.
//   rsp_o carries one word (status, found_index) per key that ran clear,
//   insert or lookup.
// Timing:
//   Clear and too-long keys answer in the cycle after the final byte.
//   Insert checks the used bit of each probed slot; lookup checks the
//   used bit of each used slot, then reads the slot RAM and compares
//   the key, and the empty slot that ends a miss gets only the used-bit
//   check. A walk makes up to TABLE_SLOTS probes. The registered
//   slot-RAM read sets the lookup pace. req_i.ready is low during a walk.
// Reset:
//   All slots empty (used bits in flops), hash at its seed, empty key.
//   No clearing pass: a clear op resets all used bits at once.
// Stalls:
//   A response holds in an output register until taken; new words are
//   accepted in the cycle it is taken, but not while it waits untaken.
`default_nettype none
module string_key_linear_probe_index_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  skil_req_if.sink   req_i,
  skil_rsp_if.source rsp_o
);
  skil_pkg::key_info_t          info;
  logic [skil_pkg::TEXT_W-1:0]  text;
  logic                         accept;
  skil_pkg::status_e            status;

  // Byte buffer and running hash.
  skil_key_buf u_key_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .key_byte_i (req_i.key_byte),
    .key_last_i (req_i.key_last),
    .info_o     (info),
    .text_o     (text)
  );

  // Probe walk over the slot table.
  skil_probe u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .func_i      (req_i.func),
    .key_last_i  (req_i.key_last),
    .entry_i     (req_i.entry_index),
    .info_i      (info),
    .text_i      (text),
    .req_ready_o (req_i.ready),
    .accept_o    (accept),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_o    (status),
    .found_o     (rsp_o.found_index)
  );

  assign rsp_o.status = status;
endmodule
`default_nettype wire

@@ hdl/skil_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module skil_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/skil_key_buf.sv @@
// Key byte buffer and djb2 hash accumulator.
// Depends on skil_pkg.
`default_nettype none
module skil_key_buf (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [7:0]                   key_byte_i,
  input  wire logic                         key_last_i,
  output skil_pkg::key_info_t               info_o,
  output logic [skil_pkg::TEXT_W-1:0]       text_o
);
  logic [31:0]                  hash_q, hash_d;
  logic [skil_pkg::LEN_W-1:0]   len_q, len_d;
  logic                         ovf_q, ovf_d;
  logic [skil_pkg::TEXT_W-1:0]  text_q;
  logic                         room;

  assign room   = (len_q != skil_pkg::LEN_W'(skil_pkg::KEY_BYTES));
  assign hash_d = (hash_q << 5) + hash_q + {24'd0, key_byte_i};
  assign len_d  = room ? len_q + 1'b1 : len_q;
  assign ovf_d  = ovf_q | ~room;

  assign info_o.home     = hash_d[skil_pkg::SLOT_W-1:0];
  assign info_o.len      = len_d;
  assign info_o.overflow = ovf_d;
  assign text_o          = text_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= skil_pkg::HASH_SEED;
      len_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (accept_i) begin
      if (key_last_i) begin
        hash_q <= skil_pkg::HASH_SEED;
        len_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        hash_q <= hash_d;
        len_q  <= len_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < skil_pkg::KEY_BYTES; i++) begin
      if (accept_i && room && len_q == skil_pkg::LEN_W'(i)) begin
        text_q[i*8 +: 8] <= key_byte_i;
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/skil_probe.sv @@
// Probe controller: slot used bits, slot row RAM, linear probe walk and
// result register. Depends on skil_pkg, skil_ram.
`default_nettype none
module skil_probe (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  input  wire logic [1:0]                  func_i,
  input  wire logic                        key_last_i,
  input  wire logic [skil_pkg::ENTRY_W-1:0] entry_i,
  input  wire skil_pkg::key_info_t         info_i,
  input  wire logic [skil_pkg::TEXT_W-1:0] text_i,
  output logic                             req_ready_o,
  output logic                             accept_o,
  output logic                             rsp_valid_o,
  input  wire logic                        rsp_ready_i,
  output skil_pkg::status_e                status_o,
  output logic [skil_pkg::ENTRY_W-1:0]     found_o
);
  localparam int unsigned SW = skil_pkg::SLOT_W;

  skil_pkg::probe_state_e state_q, state_d;
  logic [skil_pkg::TABLE_SLOTS-1:0] used_q;
  logic [SW-1:0]                    slot_q, slot_d, slot_inc;
  logic [skil_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             ins_q, ins_d;
  logic [skil_pkg::ENTRY_W-1:0]     entry_q, entry_d;
  logic [skil_pkg::LEN_W-1:0]       len_q, len_d;
  logic                             out_valid_q, out_valid_d;
  skil_pkg::status_e                status_q, status_d;
  logic [skil_pkg::ENTRY_W-1:0]     found_q, found_d;
  logic                             clear_all, set_used, we, last_probe, match;
  logic [skil_pkg::ROW_W-1:0]       rdata, wdata;
  logic [skil_pkg::TEXT_W-1:0]      mask;

  skil_ram #(.WIDTH(skil_pkg::ROW_W), .DEPTH(skil_pkg::TABLE_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_q),
    .wdata_i (wdata),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  assign wdata    = {entry_q, len_q, text_i};
  assign slot_inc = (slot_q == SW'(skil_pkg::TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
  assign last_probe = (cnt_q == skil_pkg::CNT_W'(skil_pkg::TABLE_SLOTS - 1));

  // Only bytes below the key length take part in the compare.
  always_comb begin
    for (int i = 0; i < skil_pkg::KEY_BYTES; i++) begin
      mask[i*8 +: 8] = (skil_pkg::LEN_W'(i) < len_q) ? 8'hFF : 8'h00;
    end
  end
  assign match = (rdata[skil_pkg::TEXT_W +: skil_pkg::LEN_W] == len_q) &&
                 (((rdata[skil_pkg::TEXT_W-1:0] ^ text_i) & mask) == '0);

  assign req_ready_o = (state_q == skil_pkg::PS_IDLE) && (!out_valid_q || rsp_ready_i);
  assign accept_o    = req_valid_i && req_ready_o;
  assign rsp_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    ins_d       = ins_q;
    entry_d     = entry_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    status_d    = status_q;
    found_d     = found_q;
    clear_all   = 1'b0;
    set_used    = 1'b0;
    we          = 1'b0;
    case (state_q)
      skil_pkg::PS_IDLE: begin
        if (accept_o && key_last_i) begin
          found_d = '0;
          if (func_i == skil_pkg::FN_CLEAR) begin
            clear_all   = 1'b1;
            out_valid_d = 1'b1;
            status_d    = skil_pkg::ST_OK;
          end else if (func_i == skil_pkg::FN_INSERT || func_i == skil_pkg::FN_LOOKUP) begin
            if (info_i.overflow) begin
              out_valid_d = 1'b1;
              status_d    = skil_pkg::ST_LONG;
            end else begin
              state_d = skil_pkg::PS_PROBE;
              slot_d  = info_i.home;
              cnt_d   = '0;
              ins_d   = (func_i == skil_pkg::FN_INSERT);
              entry_d = entry_i;
              len_d   = info_i.len;
            end
          end
        end
      end
      skil_pkg::PS_PROBE: begin
        if (!used_q[slot_q]) begin
          state_d     = skil_pkg::PS_IDLE;
          out_valid_d = 1'b1;
          if (ins_q) begin
            we       = 1'b1;
            set_used = 1'b1;
            status_d = skil_pkg::ST_OK;
          end else begin
            status_d = skil_pkg::ST_MISS;
          end
        end else if (ins_q) begin
          if (last_probe) begin
            state_d     = skil_pkg::PS_IDLE;
            out_valid_d = 1'b1;
            status_d    = skil_pkg::ST_FULL;
          end else begin
            slot_d = slot_inc;
            cnt_d  = cnt_q + 1'b1;
          end
        end else begin
          state_d = skil_pkg::PS_CMP;
        end
      end
      skil_pkg::PS_CMP: begin
        if (match) begin
          state_d     = skil_pkg::PS_IDLE;
          out_valid_d = 1'b1;
          status_d    = skil_pkg::ST_FOUND;
          found_d     = rdata[skil_pkg::ROW_W-1 -: skil_pkg::ENTRY_W];
        end else if (last_probe) begin
          state_d     = skil_pkg::PS_IDLE;
          out_valid_d = 1'b1;
          status_d    = skil_pkg::ST_MISS;
        end else begin
          state_d = skil_pkg::PS_PROBE;
          slot_d  = slot_inc;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      default: state_d = skil_pkg::PS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skil_pkg::PS_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (clear_all) begin
        used_q <= '0;
      end else if (set_used) begin
        used_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    cnt_q    <= cnt_d;
    ins_q    <= ins_d;
    entry_q  <= entry_d;
    len_q    <= len_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  // Nothing may be pending in the result register while a walk runs.
  a_no_result_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != skil_pkg::PS_IDLE |-> !out_valid_q)
    else $error("result pending during probe walk");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != skil_pkg::PS_IDLE |-> cnt_q < skil_pkg::CNT_W'(skil_pkg::TABLE_SLOTS))
    else $error("probe count beyond table");
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != skil_pkg::ST_FOUND |-> found_q == '0)
    else $error("found index nonzero without a hit");
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> used_q[$past(slot_q)])
    else $error("insert did not mark slot used");
endmodule
`default_nettype wire

@@ tb/sv/skil_index_checker.sv @@
// Checker for the string key linear probe index unit: watches both channels,
// predicts each response from accepted request words and compares.
// Depends on skil_pkg and skil_if.
`timescale 1ns / 1ps
module skil_index_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skil_req_if       req_i,
  skil_rsp_if       rsp_i,
  output int        fail_count_o,
  output int        pending_count_o
);
  typedef struct packed {
    skil_pkg::status_e status;
    logic [5:0]        found_index;
  } index_rsp_t;

  logic                                shadow_used  [skil_pkg::TABLE_SLOTS];
  logic [5:0]                          shadow_entry [skil_pkg::TABLE_SLOTS];
  logic [skil_pkg::LEN_W-1:0]          shadow_len   [skil_pkg::TABLE_SLOTS];
  logic [skil_pkg::KEY_BYTES-1:0][7:0] shadow_text  [skil_pkg::TABLE_SLOTS];
  logic [31:0]                         djb2_sum;
  logic [skil_pkg::KEY_BYTES-1:0][7:0] key_text;
  int                                  key_len;
  logic                                key_too_long;
  index_rsp_t                          expected_rsps[$];

  assign pending_count_o = expected_rsps.size();

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  // Runs the operation on the key end and returns its response.
  function automatic index_rsp_t run_key_op(input logic [1:0] fn, input logic [5:0] entry);
    index_rsp_t r;
    int unsigned h;
    bit done;
    r.status = skil_pkg::ST_OK;
    r.found_index = '0;
    h = djb2_sum % skil_pkg::TABLE_SLOTS;
    done = 0;
    if (fn == skil_pkg::FN_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    end else if (key_too_long) begin
      r.status = skil_pkg::ST_LONG;
    end else if (fn == skil_pkg::FN_INSERT) begin
      r.status = skil_pkg::ST_FULL;
      for (int n = 0; n < skil_pkg::TABLE_SLOTS && !done; n++) begin
        if (!shadow_used[h]) begin
          shadow_used[h]  = 1'b1;
          shadow_entry[h] = entry;
          shadow_len[h]   = skil_pkg::LEN_W'(key_len);
          shadow_text[h]  = key_text;
          r.status = skil_pkg::ST_OK;
          done = 1;
        end
        h = (h + 1) % skil_pkg::TABLE_SLOTS;
      end
    end else begin
      r.status = skil_pkg::ST_MISS;
      for (int n = 0; n < skil_pkg::TABLE_SLOTS && !done && shadow_used[h]; n++) begin
        if (shadow_len[h] == key_len) begin
          done = 1;
          for (int b = 0; b < key_len; b++)
            if (shadow_text[h][b] != key_text[b]) done = 0;
          if (done) begin
            r.status = skil_pkg::ST_FOUND;
            r.found_index = shadow_entry[h];
          end
        end
        h = (h + 1) % skil_pkg::TABLE_SLOTS;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    index_rsp_t want;
    if (!rst_ni) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      djb2_sum = skil_pkg::HASH_SEED;
      key_len = 0;
      key_too_long = 0;
      key_text = '0;
      fail_count_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with none expected");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_i.status, want.status));
          if (rsp_i.found_index !== want.found_index)
            report_mismatch($sformatf("found_index %0d, expected %0d",
                                      rsp_i.found_index, want.found_index));
        end
      end
      if (req_i.valid && req_i.ready) begin
        djb2_sum = (djb2_sum << 5) + djb2_sum + {24'd0, req_i.key_byte};
        if (key_len < skil_pkg::KEY_BYTES) begin
          key_text[key_len] = req_i.key_byte;
          key_len++;
        end else begin
          key_too_long = 1;
        end
        if (req_i.key_last) begin
          if (req_i.func != skil_pkg::FN_DROP)
            expected_rsps.push_back(run_key_op(req_i.func, req_i.entry_index));
          djb2_sum = skil_pkg::HASH_SEED;
          key_len = 0;
          key_too_long = 0;
        end
      end
    end
  end
endmodule

@@ tb/sv/string_key_linear_probe_index_unit_test.sv @@
// Top of the probe index unit testbench: clock, reset, request stimulus,
// response stalls and the verdict. Depends on skil_pkg, skil_if, the checker.
`timescale 1ns / 1ps
module string_key_linear_probe_index_unit_test;
  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  bit   calm_phase;   // no idling near the end of the run

  skil_req_if req_if ();
  skil_rsp_if rsp_if ();

  string_key_linear_probe_index_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  skil_index_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_if),
    .rsp_i           (rsp_if),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Small key pool so lookups and duplicates hit stored keys often.
  logic [7:0] key_pool [8][skil_pkg::KEY_BYTES+2];
  int         key_pool_len [8];

  // Sends one word; bursts of idle cycles precede it at random.
  task automatic send_word(input logic [1:0] fn, input logic [7:0] b,
                           input logic last, input logic [5:0] entry);
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= fn;
    req_if.key_byte    <= b;
    req_if.key_last    <= last;
    req_if.entry_index <= entry;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Sends a whole key; func and entry ride on every word of it.
  task automatic send_key(input logic [1:0] fn, input int slot, input logic [5:0] entry);
    for (int i = 0; i < key_pool_len[slot]; i++)
      send_word(fn, key_pool[slot][i], i == key_pool_len[slot] - 1, entry);
  endtask

  task automatic fill_pool_key(input int slot, input int len);
    key_pool_len[slot] = len;
    for (int i = 0; i < len; i++) key_pool[slot][i] = 8'($urandom_range(0, 255));
  endtask

  // Response side stalls in bursts too.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm_phase && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    #50ms;
    $display("string_key_linear_probe_index_unit_test NOT OK");
    $finish;
  end

  initial begin
    int roll;
    int drain;
    calm_phase = 0;
    req_if.valid = 1'b0;
    req_if.func = skil_pkg::FN_CLEAR;
    req_if.key_byte = '0;
    req_if.key_last = 1'b0;
    req_if.entry_index = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every op, too-long, zero bytes, duplicates, selector three.
    key_pool_len[0] = 1; key_pool[0][0] = 8'hFF;
    key_pool_len[1] = 1; key_pool[1][0] = 8'h00;
    fill_pool_key(2, skil_pkg::KEY_BYTES);
    fill_pool_key(3, skil_pkg::KEY_BYTES + 1);
    for (int i = 0; i < skil_pkg::KEY_BYTES; i++) key_pool[4][i] = 8'h01 << (i % 8);
    key_pool_len[4] = skil_pkg::KEY_BYTES;
    send_key(skil_pkg::FN_LOOKUP, 0, 6'h00);
    send_key(skil_pkg::FN_INSERT, 0, 6'h3F);
    send_key(skil_pkg::FN_INSERT, 1, 6'h00);
    send_key(skil_pkg::FN_INSERT, 2, 6'h2A);
    send_key(skil_pkg::FN_INSERT, 4, 6'h15);
    send_key(skil_pkg::FN_INSERT, 0, 6'h01);
    send_key(skil_pkg::FN_LOOKUP, 0, 6'h00);
    send_key(skil_pkg::FN_LOOKUP, 1, 6'h00);
    send_key(skil_pkg::FN_LOOKUP, 2, 6'h00);
    send_key(skil_pkg::FN_LOOKUP, 4, 6'h00);
    send_key(skil_pkg::FN_INSERT, 3, 6'h07);
    send_key(skil_pkg::FN_LOOKUP, 3, 6'h00);
    send_key(skil_pkg::FN_DROP, 2, 6'h00);
    send_key(skil_pkg::FN_CLEAR, 3, 6'h00);
    send_key(skil_pkg::FN_LOOKUP, 2, 6'h00);
    // Fill the table to the brim, then one more insert and a full-pass lookup.
    for (int n = 0; n <= skil_pkg::TABLE_SLOTS; n++) begin
      send_word(skil_pkg::FN_INSERT, 8'($urandom_range(0, 255)), 1'b1,
                6'($urandom_range(0, 63)));
    end
    send_key(skil_pkg::FN_LOOKUP, 2, 6'h00);
    send_key(skil_pkg::FN_CLEAR, 0, 6'h00);

    // Random: mostly inserts and lookups of pooled keys, some noise.
    for (int n = 0; n < 200; n++) begin
      if (n == 170) calm_phase = 1;
      if (n % 25 == 0) begin
        for (int s = 0; s < 8; s++) fill_pool_key(s, $urandom_range(1, skil_pkg::KEY_BYTES));
        fill_pool_key(7, $urandom_range(skil_pkg::KEY_BYTES + 1, skil_pkg::KEY_BYTES + 2));
      end
      roll = $urandom_range(0, 99);
      if (roll < 40)
        send_key(skil_pkg::FN_INSERT, $urandom_range(0, 7), 6'($urandom_range(0, 63)));
      else if (roll < 85) send_key(skil_pkg::FN_LOOKUP, $urandom_range(0, 7), 6'h00);
      else if (roll < 88) send_key(skil_pkg::FN_CLEAR, $urandom_range(0, 7), 6'h00);
      else if (roll < 92) send_key(skil_pkg::FN_DROP, $urandom_range(0, 7), 6'h00);
      else send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b1,
                     6'($urandom_range(0, 63)));
    end
    req_if.valid <= 1'b0;

    drain = 0;
    while (pending_count != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("string_key_linear_probe_index_unit_test OK");
    end else begin
      $display("string_key_linear_probe_index_unit_test NOT OK");
    end
    $finish;
  end
endmodule
